// ===== sv/volume_block_slot_cache_defines.svh =====
// Assertion macros shared by the slot cache checker.
`ifndef VOLUME_BLOCK_SLOT_CACHE_DEFINES_SVH
`define VOLUME_BLOCK_SLOT_CACHE_DEFINES_SVH

// Same-cycle implication, reset masks the check.
`define VBSC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, reset masks the check.
`define VBSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/vbsc_pkg.sv =====
// Types and constants of the volume block slot cache.
package vbsc_pkg;

   localparam int MAX_SLOTS_DEF = 256;
   localparam int MAP_WORDS_DEF = 65536;
   localparam int MAX_LODS      = 8;

   localparam logic [31:0] MAP_FLAG     = 32'h0001_0000;
   localparam logic [31:0] MAP_LOW_MASK = 32'h0000_ffff;
   localparam int          ENTRY_WORDS  = 4;

   localparam logic [4:0] SX_RESET = 5'd4;
   localparam logic [4:0] SY_RESET = 5'd4;
   localparam logic [4:0] SZ_RESET = 5'd4;
   localparam logic [2:0] TC_RESET = 3'd1;

   typedef enum logic [1:0] {
      REG_SLOTS_X  = 2'd0,
      REG_SLOTS_Y  = 2'd1,
      REG_SLOTS_Z  = 2'd2,
      REG_TEXTURES = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      A_UPLOAD = 3'd0,
      A_REVAL  = 3'd1,
      A_INVAL  = 3'd2,
      A_CLEAR  = 3'd3,
      A_STATUS = 3'd4,
      A_EMPTY  = 3'd5,
      A_MAPRD  = 3'd6,
      A_LOAD   = 3'd7
   } act_type;

   typedef enum logic [2:0] {
      ST_HIT      = 3'd0,
      ST_PLACED   = 3'd1,
      ST_NOTFOUND = 3'd2,
      ST_NOFREE   = 3'd3,
      ST_RANGE    = 3'd4
   } st_type;

   typedef struct packed {
      logic [4:0] x;
      logic [4:0] y;
      logic [4:0] z;
      logic [2:0] t;
   } coord_type;

   typedef struct packed {
      logic wr;
      logic rd;
      logic clr;
   } pt_ctl_type;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE,
      S_EA1, S_EA2, S_EA3, S_EA4, S_EA5, S_EA6, S_POSTEA,
      S_SCAN, S_SCANEND, S_DISP,
      S_OLD1, S_OLD2,
      S_EV0, S_EV1, S_EV2, S_EV3, S_NW,
      S_CLR, S_CLRW, S_MRD, S_MRD2,
      S_LD, S_BS1, S_BS2, S_BS3,
      S_RESP
   } state_type;

endpackage

// ===== sv/volume_block_slot_cache.sv =====
// Slot table and page table sequencer of the volume block cache.
//
// channel | dir | accepted when
// req_*   | in  | start & !busy
// rsp_*   | out | rsp_strobe (one cycle, no back-pressure)
// csr_*   | in  | csr_valid & csr_ready
//
// Slot searches walk the slot table one entry a cycle through the tag and
// stamp memories; uploads add entry address math on one shared multiplier
// and page table writes. Clear and load lod zero the page table up to the
// top base, one word a cycle. After reset a sweep zeroes all MAP_WORDS page
// table words with busy high. One transaction at a time; the result shows
// for one cycle, in the cycle that busy drops.
module volume_block_slot_cache import vbsc_pkg::*; #(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF,
   parameter int MAP_WORDS = MAP_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [9:0]  req_blk_x,
   input  logic [9:0]  req_blk_y,
   input  logic [9:0]  req_blk_z,
   input  logic [2:0]  req_lod,
   input  logic [15:0] req_map_addr,
   input  logic [10:0] req_dim_x,
   input  logic [10:0] req_dim_y,
   input  logic [10:0] req_dim_z,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_slot_x,
   output logic [3:0]  rsp_slot_y,
   output logic [3:0]  rsp_slot_z,
   output logic [1:0]  rsp_slot_texture,
   output logic        rsp_is_valid,
   output logic        rsp_is_cached,
   output logic        rsp_evicted_block,
   output logic [8:0]  rsp_empty_count,
   output logic [31:0] rsp_map_word,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_wdata
);

   localparam int SW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CW   = SW + 1;
   localparam int AW   = $clog2(MAP_WORDS);
   localparam int BW   = AW + 1;
   localparam int TAGW = 33;

   state_type state_ff, state_in;

   logic [4:0] sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic [2:0] tc_ff, tc_in;

   act_type     act_ff, act_in;
   logic [9:0]  rx_ff, rx_in, ry_ff, ry_in, rz_ff, rz_in;
   logic [2:0]  rl_ff, rl_in;
   logic [15:0] ma_ff, ma_in;
   logic [10:0] ddx_ff, ddx_in, ddy_ff, ddy_in, ddz_ff, ddz_in;

   logic [9:0]  atx_ff, atx_in, aty_ff, aty_in, atz_ff, atz_in;
   logic [2:0]  atl_ff, atl_in;
   logic        ev_ff, ev_in;
   logic [31:0] prod_ff, prod_in, acc_ff, acc_in;
   logic [33:0] ea_ff, ea_in;
   logic        ok_ff, ok_in;
   logic [AW-1:0] naddr_ff, naddr_in;
   logic        nok_ff, nok_in;

   logic [9:0]  dimx_ff [MAX_LODS];
   logic [9:0]  dimx_in [MAX_LODS];
   logic [9:0]  dimy_ff [MAX_LODS];
   logic [9:0]  dimy_in [MAX_LODS];
   logic [9:0]  dimz_ff [MAX_LODS];
   logic [9:0]  dimz_in [MAX_LODS];
   logic [MAX_LODS-1:0] loaded_ff, loaded_in;
   logic [BW-1:0] base_ff [MAX_LODS+1];
   logic [BW-1:0] base_in [MAX_LODS+1];
   logic [2:0]  li_ff, li_in;

   logic [MAX_SLOTS-1:0] occ_ff, occ_in, val_ff, val_in, cac_ff, cac_in;
   logic [31:0] use_ff, use_in;

   logic [SW-1:0] n_ff, n_in;
   coord_type     cur_ff, cur_in;
   logic          pv_ff, pv_in;
   logic [SW-1:0] pn_ff, pn_in;
   coord_type     pc_ff, pc_in;

   logic          fok_ff, fok_in, aok_ff, aok_in, bok_ff, bok_in;
   logic [SW-1:0] fn_ff, fn_in, an_ff, an_in, bn_ff, bn_in;
   coord_type     fc_ff, fc_in, ac_ff, ac_in, bc_ff, bc_in;
   logic [31:0]   ast_ff, ast_in, bst_ff, bst_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic [SW-1:0] s_ff, s_in;
   coord_type     sc_ff, sc_in;
   logic [1:0]    wi_ff, wi_in;

   st_type      rst_ff, rst_in;
   coord_type   rc_ff, rc_in;
   logic        rv_ff, rv_in, rca_ff, rca_in, rev_ff, rev_in;
   logic [8:0]  rem_ff, rem_in;
   logic [31:0] rw_ff, rw_in;
   logic        strobe_ff, strobe_in;

   logic [TAGW-1:0] tag_mem [MAX_SLOTS];
   logic [31:0]     stamp_mem [MAX_SLOTS];
   logic [TAGW-1:0] tag_rd_ff;
   logic [31:0]     stamp_rd_ff;
   logic [SW-1:0]   tm_ra, tm_wa;
   logic            tag_we, stamp_we;

   pt_ctl_type    pt_ctl;
   logic [AW-1:0] pt_wa, pt_ra;
   logic [31:0]   pt_wd, pt_rdata;
   logic [BW-1:0] top;
   logic          clr_busy;

   logic [20:0] mul_a;
   logic [10:0] mul_b;
   logic [31:0] mul_p;
   logic [2:0]  mlod;
   logic [10:0] mdx, mdy, mdz;

   logic [TAGW-1:0] rtag;
   logic        accept, act_zero, need_cached, sc_last;
   logic        e_occ, e_val, e_cac, e_match;
   logic [31:0] e_stamp;
   logic [33:0] nb;
   logic [BW-1:0] nb_sat;
   logic        evict;

   assign accept    = start && state_ff == S_IDLE;
   assign busy      = state_ff != S_IDLE;
   assign csr_ready = 1'b1;
   assign top       = base_ff[MAX_LODS];
   assign rtag      = {rl_ff, rz_ff, ry_ff, rx_ff};
   assign act_zero  = sx_ff == '0 || sy_ff == '0 || sz_ff == '0 || tc_ff == '0;
   assign need_cached = act_ff == A_UPLOAD || act_ff == A_REVAL;
   assign sc_last   = n_ff == SW'(MAX_SLOTS - 1) ||
                      (cur_ff.x == sx_ff - 5'd1 && cur_ff.y == sy_ff - 5'd1 &&
                       cur_ff.z == sz_ff - 5'd1 && cur_ff.t == tc_ff - 3'd1);

   // shared multiplier: entry address and lod size terms
   assign mlod = (state_ff == S_BS1 || state_ff == S_BS2 || state_ff == S_BS3) ? li_ff
                                                                              : atl_ff;
   assign mdx = {1'b0, dimx_ff[mlod]} + 11'd1;
   assign mdy = {1'b0, dimy_ff[mlod]} + 11'd1;
   assign mdz = {1'b0, dimz_ff[mlod]} + 11'd1;

   always_comb begin
      unique case (state_ff)
         S_EA2:   begin mul_a = prod_ff[20:0];   mul_b = {1'b0, atz_ff}; end
         S_EA3:   begin mul_a = 21'(aty_ff);     mul_b = mdx;            end
         S_BS2:   begin mul_a = prod_ff[20:0];   mul_b = mdz;            end
         default: begin mul_a = 21'(mdx);        mul_b = mdy;            end
      endcase
   end
   assign mul_p = {11'd0, mul_a} * {21'd0, mul_b};

   // pipelined slot evaluation, one entry per cycle
   assign e_occ   = occ_ff[pn_ff];
   assign e_val   = val_ff[pn_ff];
   assign e_cac   = cac_ff[pn_ff];
   assign e_stamp = e_occ ? stamp_rd_ff : 32'd0;
   assign e_match = e_occ && tag_rd_ff == rtag && (e_cac || !need_cached);

   assign nb     = 34'(base_ff[li_ff]) + (loaded_ff[li_ff] ? {prod_ff, 2'b00} : 34'd0);
   assign nb_sat = (nb > 34'(MAP_WORDS)) ? BW'(MAP_WORDS) : nb[BW-1:0];
   assign evict  = occ_ff[s_ff] && tag_rd_ff != rtag;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: if (!clr_busy) state_in = S_IDLE;
         S_IDLE: begin
            if (start) begin
               unique case (act_type'(req_action))
                  A_UPLOAD, A_REVAL: state_in = S_EA1;
                  A_CLEAR:           state_in = S_CLR;
                  A_MAPRD:           state_in = S_MRD;
                  A_LOAD:            state_in = ({1'b0, req_lod} >= 4'(MAX_LODS)) ? S_RESP
                                                                                : S_LD;
                  default:           state_in = act_zero ? S_DISP : S_SCAN;
               endcase
            end
         end
         S_EA1:  state_in = S_EA2;
         S_EA2:  state_in = S_EA3;
         S_EA3:  state_in = S_EA4;
         S_EA4:  state_in = S_EA5;
         S_EA5:  state_in = S_EA6;
         S_EA6:  state_in = ev_ff ? S_EV0 : S_POSTEA;
         S_POSTEA: begin
            if (act_ff == A_UPLOAD && !ok_ff) state_in = S_RESP;
            else state_in = act_zero ? S_DISP : S_SCAN;
         end
         S_SCAN:    if (sc_last) state_in = S_SCANEND;
         S_SCANEND: state_in = S_DISP;
         S_DISP: begin
            priority if (act_ff == A_UPLOAD) begin
               state_in = (fok_ff || aok_ff || bok_ff) ? S_OLD1 : S_RESP;
            end else if (act_ff == A_REVAL) begin
               state_in = (fok_ff && nok_ff) ? S_NW : S_RESP;
            end else begin
               state_in = S_RESP;
            end
         end
         S_OLD1: state_in = S_OLD2;
         S_OLD2: state_in = evict ? S_EA1 : S_NW;
         S_EV0:  state_in = ok_ff ? S_EV1 : S_NW;
         S_EV1:  state_in = S_EV2;
         S_EV2:  state_in = S_EV3;
         S_EV3:  state_in = S_NW;
         S_NW:   if (wi_ff == 2'(ENTRY_WORDS - 1)) state_in = S_RESP;
         S_CLR:  state_in = S_CLRW;
         S_CLRW: if (!clr_busy) state_in = S_RESP;
         S_MRD:  state_in = (32'(ma_ff) >= 32'(top)) ? S_RESP : S_MRD2;
         S_MRD2: state_in = S_RESP;
         S_LD:   state_in = S_BS1;
         S_BS1:  state_in = S_BS2;
         S_BS2:  state_in = S_BS3;
         S_BS3:  state_in = (li_ff == 3'(MAX_LODS - 1)) ? S_CLRW : S_BS1;
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and control outputs
   always_comb begin
      sx_in = sx_ff; sy_in = sy_ff; sz_in = sz_ff; tc_in = tc_ff;
      act_in = act_ff; rx_in = rx_ff; ry_in = ry_ff; rz_in = rz_ff; rl_in = rl_ff;
      ma_in = ma_ff; ddx_in = ddx_ff; ddy_in = ddy_ff; ddz_in = ddz_ff;
      atx_in = atx_ff; aty_in = aty_ff; atz_in = atz_ff; atl_in = atl_ff; ev_in = ev_ff;
      prod_in = prod_ff; acc_in = acc_ff; ea_in = ea_ff; ok_in = ok_ff;
      naddr_in = naddr_ff; nok_in = nok_ff;
      dimx_in = dimx_ff; dimy_in = dimy_ff; dimz_in = dimz_ff;
      loaded_in = loaded_ff; base_in = base_ff; li_in = li_ff;
      occ_in = occ_ff; val_in = val_ff; cac_in = cac_ff; use_in = use_ff;
      n_in = n_ff; cur_in = cur_ff;
      pv_in = state_ff == S_SCAN; pn_in = n_ff; pc_in = cur_ff;
      fok_in = fok_ff; fn_in = fn_ff; fc_in = fc_ff;
      aok_in = aok_ff; an_in = an_ff; ac_in = ac_ff; ast_in = ast_ff;
      bok_in = bok_ff; bn_in = bn_ff; bc_in = bc_ff; bst_in = bst_ff;
      cnt_in = cnt_ff;
      s_in = s_ff; sc_in = sc_ff; wi_in = wi_ff;
      rst_in = rst_ff; rc_in = rc_ff; rv_in = rv_ff; rca_in = rca_ff;
      rev_in = rev_ff; rem_in = rem_ff; rw_in = rw_ff;
      strobe_in = state_ff == S_RESP;
      tm_ra = (state_ff == S_SCAN) ? n_ff : s_ff;
      tm_wa = (state_ff == S_DISP) ? fn_ff : s_ff;
      tag_we = 1'b0; stamp_we = 1'b0;
      pt_ctl = '0; pt_wa = naddr_ff; pt_wd = 32'd0;
      pt_ra = AW'(ma_ff); pt_lim = top;

      if (csr_valid && csr_ready) begin
         unique case (csr_idx_type'(csr_index))
            REG_SLOTS_X:  sx_in = csr_wdata;
            REG_SLOTS_Y:  sy_in = csr_wdata;
            REG_SLOTS_Z:  sz_in = csr_wdata;
            REG_TEXTURES: tc_in = csr_wdata[2:0];
            default: ;
         endcase
      end

      if (pv_ff) begin
         if (e_match && !fok_ff) begin
            fok_in = 1'b1; fn_in = pn_ff; fc_in = pc_ff;
         end
         if (!e_val && !e_cac && (!aok_ff || e_stamp < ast_ff)) begin
            aok_in = 1'b1; an_in = pn_ff; ac_in = pc_ff; ast_in = e_stamp;
         end
         if (!e_val && (!bok_ff || e_stamp < bst_ff)) begin
            bok_in = 1'b1; bn_in = pn_ff; bc_in = pc_ff; bst_in = e_stamp;
         end
         if (!e_val) cnt_in = cnt_ff + CW'(1);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in = act_type'(req_action);
               rx_in = req_blk_x; ry_in = req_blk_y; rz_in = req_blk_z; rl_in = req_lod;
               ma_in = req_map_addr;
               ddx_in = req_dim_x; ddy_in = req_dim_y; ddz_in = req_dim_z;
               atx_in = req_blk_x; aty_in = req_blk_y; atz_in = req_blk_z;
               atl_in = req_lod; ev_in = 1'b0;
               n_in = '0; cur_in = '0;
               fok_in = 1'b0; aok_in = 1'b0; bok_in = 1'b0; cnt_in = '0;
               wi_in = '0; li_in = '0;
               rst_in = ST_HIT; rc_in = '0; rv_in = 1'b0; rca_in = 1'b0;
               rev_in = 1'b0; rem_in = '0; rw_in = '0;
               if (act_type'(req_action) == A_LOAD && {1'b0, req_lod} >= 4'(MAX_LODS)) begin
                  rst_in = ST_RANGE;
               end
            end
         end
         S_EA1: prod_in = mul_p;
         S_EA2: prod_in = mul_p;
         S_EA3: begin acc_in = prod_ff; prod_in = mul_p; end
         S_EA4: acc_in = acc_ff + prod_ff + 32'(atx_ff);
         S_EA5: ea_in = {acc_ff, 2'b00} + 34'(base_ff[atl_ff]);
         S_EA6: ok_in = loaded_ff[atl_ff] && (35'(ea_ff) + 35'd3 < 35'(top));
         S_POSTEA: begin
            naddr_in = ea_ff[AW-1:0];
            nok_in = ok_ff;
            if (act_ff == A_UPLOAD && !ok_ff) rst_in = ST_RANGE;
         end
         S_SCAN: begin
            n_in = n_ff + SW'(1);
            if (cur_ff.x == sx_ff - 5'd1) begin
               cur_in.x = '0;
               if (cur_ff.y == sy_ff - 5'd1) begin
                  cur_in.y = '0;
                  if (cur_ff.z == sz_ff - 5'd1) begin
                     cur_in.z = '0;
                     cur_in.t = cur_ff.t + 3'd1;
                  end else begin
                     cur_in.z = cur_ff.z + 5'd1;
                  end
               end else begin
                  cur_in.y = cur_ff.y + 5'd1;
               end
            end else begin
               cur_in.x = cur_ff.x + 5'd1;
            end
         end
         S_DISP: begin
            unique case (act_ff)
               A_UPLOAD: begin
                  priority if (fok_ff) begin
                     s_in = fn_ff; sc_in = fc_ff; rst_in = ST_HIT;
                  end else if (aok_ff) begin
                     s_in = an_ff; sc_in = ac_ff; rst_in = ST_PLACED;
                  end else if (bok_ff) begin
                     s_in = bn_ff; sc_in = bc_ff; rst_in = ST_PLACED;
                  end else begin
                     rst_in = ST_NOFREE;
                  end
               end
               A_REVAL: begin
                  priority if (!fok_ff) begin
                     rst_in = ST_NOTFOUND;
                  end else if (!nok_ff) begin
                     rst_in = ST_RANGE;
                  end else begin
                     val_in[fn_ff] = 1'b1;
                     stamp_we = 1'b1;
                     use_in = use_ff + 32'd1;
                     sc_in = fc_ff; rc_in = fc_ff;
                  end
               end
               A_INVAL, A_STATUS: begin
                  if (!fok_ff) begin
                     rst_in = ST_NOTFOUND;
                  end else begin
                     rc_in = fc_ff;
                     if (act_ff == A_INVAL) begin
                        val_in[fn_ff] = 1'b0;
                     end else begin
                        rv_in = val_ff[fn_ff];
                        rca_in = cac_ff[fn_ff];
                     end
                  end
               end
               default: rem_in = 9'(cnt_ff);
            endcase
         end
         S_OLD2: begin
            rc_in = sc_ff;
            rev_in = evict;
            tag_we = 1'b1; stamp_we = 1'b1;
            occ_in[s_ff] = 1'b1; val_in[s_ff] = 1'b1; cac_in[s_ff] = 1'b1;
            use_in = use_ff + 32'd1;
            if (evict) begin
               atx_in = tag_rd_ff[9:0];
               aty_in = tag_rd_ff[19:10];
               atz_in = tag_rd_ff[29:20];
               atl_in = tag_rd_ff[32:30];
               ev_in = 1'b1;
            end
         end
         S_EV0: begin
            if (ok_ff) begin
               pt_ctl.wr = 1'b1; pt_ctl.rd = 1'b1;
               pt_wa = ea_ff[AW-1:0];
               pt_ra = AW'(ea_ff + 34'd3);
            end
         end
         S_EV1: begin pt_ctl.wr = 1'b1; pt_wa = AW'(ea_ff + 34'd1); end
         S_EV2: begin pt_ctl.wr = 1'b1; pt_wa = AW'(ea_ff + 34'd2); end
         S_EV3: begin
            pt_ctl.wr = 1'b1;
            pt_wa = AW'(ea_ff + 34'd3);
            pt_wd = pt_rdata & MAP_LOW_MASK;
         end
         S_NW: begin
            pt_ctl.wr = 1'b1;
            pt_wa = naddr_ff + AW'(wi_ff);
            unique case (wi_ff)
               2'd0:    pt_wd = 32'(sc_ff.x);
               2'd1:    pt_wd = 32'(sc_ff.y);
               2'd2:    pt_wd = 32'(sc_ff.z);
               default: pt_wd = 32'(sc_ff.t) | MAP_FLAG;
            endcase
            wi_in = wi_ff + 2'd1;
         end
         S_CLR: begin
            val_in = '0;
            pt_ctl.clr = 1'b1;
         end
         S_MRD: begin
            if (32'(ma_ff) >= 32'(top)) rst_in = ST_RANGE;
            else pt_ctl.rd = 1'b1;
         end
         S_MRD2: rw_in = pt_rdata;
         S_LD: begin
            // saturate each dimension to 1..1024, stored less one
            dimx_in[rl_ff] = (ddx_ff == '0) ? 10'd0 : (ddx_ff > 11'd1024) ? 10'd1023
                                                    : 10'(ddx_ff - 11'd1);
            dimy_in[rl_ff] = (ddy_ff == '0) ? 10'd0 : (ddy_ff > 11'd1024) ? 10'd1023
                                                    : 10'(ddy_ff - 11'd1);
            dimz_in[rl_ff] = (ddz_ff == '0) ? 10'd0 : (ddz_ff > 11'd1024) ? 10'd1023
                                                    : 10'(ddz_ff - 11'd1);
            loaded_in[rl_ff] = 1'b1;
            pt_ctl.clr = 1'b1;
         end
         S_BS1: prod_in = mul_p;
         S_BS2: prod_in = mul_p;
         S_BS3: begin
            for (int k = 1; k <= MAX_LODS; k++) begin
               if (4'(k) == {1'b0, li_ff} + 4'd1) base_in[k] = nb_sat;
            end
            li_in = li_ff + 3'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_INIT;
         sx_ff <= SX_RESET; sy_ff <= SY_RESET; sz_ff <= SZ_RESET; tc_ff <= TC_RESET;
         occ_ff    <= '0;
         val_ff    <= '0;
         cac_ff    <= '0;
         use_ff    <= '0;
         loaded_ff <= '0;
         for (int k = 0; k <= MAX_LODS; k++) base_ff[k] <= '0;
         pv_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sx_ff <= sx_in; sy_ff <= sy_in; sz_ff <= sz_in; tc_ff <= tc_in;
         occ_ff    <= occ_in;
         val_ff    <= val_in;
         cac_ff    <= cac_in;
         use_ff    <= use_in;
         loaded_ff <= loaded_in;
         base_ff   <= base_in;
         pv_ff     <= pv_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in; rx_ff <= rx_in; ry_ff <= ry_in; rz_ff <= rz_in; rl_ff <= rl_in;
      ma_ff <= ma_in; ddx_ff <= ddx_in; ddy_ff <= ddy_in; ddz_ff <= ddz_in;
      atx_ff <= atx_in; aty_ff <= aty_in; atz_ff <= atz_in; atl_ff <= atl_in;
      ev_ff <= ev_in;
      prod_ff <= prod_in; acc_ff <= acc_in; ea_ff <= ea_in; ok_ff <= ok_in;
      naddr_ff <= naddr_in; nok_ff <= nok_in;
      dimx_ff <= dimx_in; dimy_ff <= dimy_in; dimz_ff <= dimz_in;
      li_ff <= li_in;
      n_ff <= n_in; cur_ff <= cur_in; pn_ff <= pn_in; pc_ff <= pc_in;
      fok_ff <= fok_in; fn_ff <= fn_in; fc_ff <= fc_in;
      aok_ff <= aok_in; an_ff <= an_in; ac_ff <= ac_in; ast_ff <= ast_in;
      bok_ff <= bok_in; bn_ff <= bn_in; bc_ff <= bc_in; bst_ff <= bst_in;
      cnt_ff <= cnt_in;
      s_ff <= s_in; sc_ff <= sc_in; wi_ff <= wi_in;
      rst_ff <= rst_in; rc_ff <= rc_in; rv_ff <= rv_in; rca_ff <= rca_in;
      rev_ff <= rev_in; rem_ff <= rem_in; rw_ff <= rw_in;
   end

   // slot tag and stamp memories
   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[tm_wa] <= rtag;
      end
      if (stamp_we) begin
         stamp_mem[tm_wa] <= use_ff + 32'd1;
      end
      tag_rd_ff   <= tag_mem[tm_ra];
      stamp_rd_ff <= stamp_mem[tm_ra];
   end

   logic [BW-1:0] pt_lim;

   vbsc_ptab #(
      .MAP_WORDS (MAP_WORDS)
   ) u_ptab (
      .clock    (clock),
      .reset    (reset),
      .ctl      (pt_ctl),
      .waddr    (pt_wa),
      .wdata    (pt_wd),
      .raddr    (pt_ra),
      .clr_lim  (pt_lim),
      .rdata    (pt_rdata),
      .clr_busy (clr_busy)
   );

   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = rst_ff;
   assign rsp_slot_x        = rc_ff.x[3:0];
   assign rsp_slot_y        = rc_ff.y[3:0];
   assign rsp_slot_z        = rc_ff.z[3:0];
   assign rsp_slot_texture  = rc_ff.t[1:0];
   assign rsp_is_valid      = rv_ff;
   assign rsp_is_cached     = rca_ff;
   assign rsp_evicted_block = rev_ff;
   assign rsp_empty_count   = rem_ff;
   assign rsp_map_word      = rw_ff;

endmodule

// ===== sv/vbsc_ptab.sv =====
// Page table memory with its zeroing sweep.
module vbsc_ptab import vbsc_pkg::*; #(
   parameter int MAP_WORDS = MAP_WORDS_DEF,
   localparam int AW = $clog2(MAP_WORDS),
   localparam int BW = AW + 1
) (
   input  logic          clock,
   input  logic          reset,
   input  pt_ctl_type    ctl,
   input  logic [AW-1:0] waddr,
   input  logic [31:0]   wdata,
   input  logic [AW-1:0] raddr,
   input  logic [BW-1:0] clr_lim,
   output logic [31:0]   rdata,
   output logic          clr_busy
);

   logic [31:0]   mem [MAP_WORDS];
   logic          busy_ff, busy_in;
   logic [BW-1:0] cnt_ff, cnt_in;
   logic [BW-1:0] lim_ff, lim_in;
   logic [31:0]   rdata_ff;
   logic          we;
   logic [AW-1:0] wa;
   logic [31:0]   wd;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      lim_in  = lim_ff;
      if (busy_ff) begin
         cnt_in = cnt_ff + BW'(1);
         if (cnt_ff + BW'(1) == lim_ff) begin
            busy_in = 1'b0;
         end
      end else if (ctl.clr && clr_lim != '0) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         lim_in  = clr_lim;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         lim_ff  <= BW'(MAP_WORDS);
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         lim_ff  <= lim_in;
      end
   end

   // sweep owns the write port while it runs
   assign we = busy_ff | ctl.wr;
   assign wa = busy_ff ? cnt_ff[AW-1:0] : waddr;
   assign wd = busy_ff ? 32'd0 : wdata;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (ctl.rd) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata    = rdata_ff;
   assign clr_busy = busy_ff;

endmodule

// ===== sv/vbsc_checker.sv =====
// Port-level checks of the slot cache, bound to the top level.
`include "volume_block_slot_cache_defines.svh"

module vbsc_checker import vbsc_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [2:0]  req_action,
   input logic [9:0]  req_blk_x,
   input logic [9:0]  req_blk_y,
   input logic [9:0]  req_blk_z,
   input logic [2:0]  req_lod,
   input logic [15:0] req_map_addr,
   input logic [10:0] req_dim_x,
   input logic [10:0] req_dim_y,
   input logic [10:0] req_dim_z,
   input logic        rsp_strobe,
   input logic [2:0]  rsp_status,
   input logic [3:0]  rsp_slot_x,
   input logic [3:0]  rsp_slot_y,
   input logic [3:0]  rsp_slot_z,
   input logic [1:0]  rsp_slot_texture,
   input logic        rsp_is_valid,
   input logic        rsp_is_cached,
   input logic        rsp_evicted_block,
   input logic [8:0]  rsp_empty_count,
   input logic [31:0] rsp_map_word,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [1:0]  csr_index,
   input logic [4:0]  csr_wdata
);

   `VBSC_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "accepted transaction did not raise busy")
   `VBSC_ASSERT_NEXT(a_one_result, clock, reset, rsp_strobe, !rsp_strobe, "result strobe longer than one cycle")
   `VBSC_ASSERT_NOW(a_result_after_work, clock, reset, rsp_strobe, $past(busy), "result without a transaction in flight")
   `VBSC_ASSERT_NOW(a_evict_on_upload, clock, reset, rsp_strobe && rsp_evicted_block, rsp_status == ST_HIT || rsp_status == ST_PLACED, "eviction reported on a failed request")

endmodule

bind volume_block_slot_cache vbsc_checker u_vbsc_checker (.*);
